/* rtl/ssort_pkg.sv */
// shared types and constants for the selection sort engine
`default_nettype none

package ssort_pkg;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_EMIT_RD,
    ST_EMIT_WR
  } sort_state_t;

endpackage

`default_nettype wire

/* rtl/selection_sort_engine.sv */
// top level of the selection sort engine
`default_nettype none

// Collects signed 32-bit values, one per input transaction, into a store of
// MAX_ELEMS entries; the transaction with last set closes the set, values
// beyond capacity are dropped. The closed set is selection sorted in place,
// ascending, and returned one result transaction per element, last_out on the
// final one. Loading takes one transaction per cycle, unless the two-entry
// queue in front of the back end is full; that queue can take up to two
// transactions of the next set while the back end sorts. Sorting costs one
// store read per compare, and each result is read from the store and then
// pushed to the output queue. The store has a single read port.

module selection_sort_engine #(
  parameter int unsigned MAX_ELEMS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire ssort_pkg::in_item_t  in_data,
  output logic                      empty,
  input  wire logic                 pop,
  output ssort_pkg::out_item_t      out_data
);

  import ssort_pkg::*;

  localparam int unsigned IW     = $clog2(MAX_ELEMS);
  localparam int unsigned QWidth = $bits(in_item_t) + 1 + IW;
  localparam int unsigned QDepth = 2;
  localparam int unsigned ODepth = 2;

  logic              fr_push;
  in_item_t          fr_item;
  logic              fr_keep;
  logic [IW-1:0]     fr_idx;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [QWidth-1:0] q_wdata;
  logic [QWidth-1:0] q_rdata;
  in_item_t          q_item;
  logic              q_keep;
  logic [IW-1:0]     q_idx;
  logic              ob_push;
  logic              ob_full;
  out_item_t         ob_item;

  ssort_front #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .in_data(in_data),
    .q_full (q_full),
    .q_push (fr_push),
    .q_item (fr_item),
    .q_keep (fr_keep),
    .q_idx  (fr_idx)
  );

  assign q_wdata = {fr_item, fr_keep, fr_idx};
  assign {q_item, q_keep, q_idx} = q_rdata;

  ssort_fifo #(
    .WIDTH(QWidth),
    .DEPTH(QDepth)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (fr_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  ssort_back #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .q_item (q_item),
    .q_keep (q_keep),
    .q_idx  (q_idx),
    .q_pop  (q_pop),
    .o_full (ob_full),
    .o_push (ob_push),
    .o_item (ob_item)
  );

  ssort_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(ODepth)
  ) u_out (
    .clk  (clk),
    .rst_n(rst_n),
    .push (ob_push),
    .wdata(ob_item),
    .full (ob_full),
    .pop  (pop),
    .rdata(out_data),
    .empty(empty)
  );

  // back end never pushes a result into a full output queue
  a_no_out_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ob_push |-> !ob_full)
    else $error("result pushed into full output queue");

  // back end only pops a queued item that is there
  a_no_q_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("item queue popped while empty");

  // a transaction the front keeps always gets a slot inside the store
  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fr_push && fr_keep) |-> ((32)'(fr_idx) < MAX_ELEMS))
    else $error("store slot beyond capacity");

  // reset leaves no stale results behind
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

`default_nettype wire

/* rtl/ssort_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module ssort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* rtl/ssort_fifo.sv */
// small register-based fifo used as the decoupling queues
`default_nettype none

module ssort_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* rtl/ssort_front.sv */
// input side: accepts transactions, assigns store slots and flags overflow drops
`default_nettype none

module ssort_front #(
  parameter int unsigned MAX_ELEMS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  output logic                              full,
  input  wire ssort_pkg::in_item_t          in_data,
  input  wire logic                         q_full,
  output logic                              q_push,
  output ssort_pkg::in_item_t               q_item,
  output logic                              q_keep,
  output logic [$clog2(MAX_ELEMS)-1:0]      q_idx
);

  localparam int unsigned IW = $clog2(MAX_ELEMS);
  localparam int unsigned CW = $clog2(MAX_ELEMS + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;
  assign q_item = in_data;
  assign q_keep = (cnt_r < CW'(MAX_ELEMS));
  assign q_idx  = cnt_r[IW-1:0];

  // count restarts with every closing transaction, saturates at capacity
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_data.last) begin
        cnt_nxt = '0;
      end else if (q_keep) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/ssort_back.sv */
// back end: element store, selection sort sequencer and result emission
`default_nettype none

module ssort_back #(
  parameter int unsigned MAX_ELEMS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire ssort_pkg::in_item_t          q_item,
  input  wire logic                         q_keep,
  input  wire logic [$clog2(MAX_ELEMS)-1:0] q_idx,
  output logic                              q_pop,
  input  wire logic                         o_full,
  output logic                              o_push,
  output ssort_pkg::out_item_t              o_item
);

  import ssort_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ELEMS);
  localparam int unsigned CW = $clog2(MAX_ELEMS + 1);

  sort_state_t       state_r, state_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [IW-1:0]     ptr_r, ptr_nxt;
  logic              pv_r, pv_nxt;
  logic [IW-1:0]     pidx_r, pidx_nxt;
  logic [DataW-1:0]  min_r, min_nxt;
  logic [IW-1:0]     midx_r, midx_nxt;
  logic [DataW-1:0]  first_r, first_nxt;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [DataW-1:0]  ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [DataW-1:0]  rd_data;

  logic [CW-1:0]     load_n;
  logic              closing;
  logic              at_last;
  logic              more_passes;

  ssort_ram #(
    .WIDTH(DataW),
    .DEPTH(MAX_ELEMS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  // a dropped closing transaction means the store is full
  assign load_n      = q_keep ? CW'(CW'(q_idx) + 1'b1) : CW'(MAX_ELEMS);
  assign closing     = !q_empty && q_item.last;
  assign at_last     = (CW'(ptr_r) == n_r - 1'b1);
  assign more_passes = ((CW + 1)'(i_r) + (CW + 1)'(2)) < (CW + 1)'(n_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (closing) begin
          state_nxt = (load_n == CW'(1)) ? ST_EMIT_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (at_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:   state_nxt = ST_SWAP_A;
      ST_SWAP_A:  state_nxt = ST_SWAP_B;
      ST_SWAP_B:  state_nxt = more_passes ? ST_SCAN : ST_EMIT_RD;
      ST_EMIT_RD: state_nxt = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (!o_full) begin
          state_nxt = at_last ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default:    state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = midx_r;
    ram_wdata = first_r;
    ram_raddr = ptr_r;
    o_push    = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        q_pop     = !q_empty;
        ram_we    = !q_empty && q_keep;
        ram_waddr = q_idx;
        ram_wdata = q_item.value;
      end
      ST_SWAP_A: begin
        ram_we    = 1'b1;
        ram_waddr = midx_r;
        ram_wdata = first_r;
      end
      ST_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = min_r;
      end
      ST_EMIT_WR: begin
        o_push = !o_full;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign o_item.sorted_value = rd_data;
  assign o_item.last_out     = at_last;

  // datapath
  always_comb begin
    n_nxt     = n_r;
    i_nxt     = i_r;
    ptr_nxt   = ptr_r;
    pv_nxt    = 1'b0;
    pidx_nxt  = pidx_r;
    min_nxt   = min_r;
    midx_nxt  = midx_r;
    first_nxt = first_r;

    // read data for the index issued last cycle
    if (pv_r) begin
      if (pidx_r == i_r) begin
        min_nxt   = rd_data;
        midx_nxt  = i_r;
        first_nxt = rd_data;
      end else if ($signed(min_r) > $signed(rd_data)) begin
        min_nxt  = rd_data;
        midx_nxt = pidx_r;
      end
    end

    case (state_r)
      ST_LOAD: begin
        if (closing) begin
          n_nxt   = load_n;
          i_nxt   = '0;
          ptr_nxt = '0;
        end
      end
      ST_SCAN: begin
        pv_nxt   = 1'b1;
        pidx_nxt = ptr_r;
        if (!at_last) begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_SWAP_B: begin
        i_nxt   = i_r + 1'b1;
        ptr_nxt = more_passes ? i_r + 1'b1 : '0;
      end
      ST_EMIT_WR: begin
        if (!o_full) begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      default: begin
        pv_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      pv_r    <= 1'b0;
      n_r     <= '0;
      i_r     <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= pv_nxt;
      n_r     <= n_nxt;
      i_r     <= i_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r  <= pidx_nxt;
    min_r   <= min_nxt;
    midx_r  <= midx_nxt;
    first_r <= first_nxt;
  end

endmodule

`default_nettype wire

/* tb/sv/sort_order_checker.sv */
// checker for the selection sort engine: predicts sorted output and compares each result
`default_nettype none

module sort_order_checker #(
  parameter int unsigned StoreDepth = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire logic                 full,
  input  wire ssort_pkg::in_item_t  in_data,
  input  wire logic                 empty,
  input  wire logic                 pop,
  input  wire ssort_pkg::out_item_t out_data,
  output int unsigned               mismatches,
  output int unsigned               outstanding
);

  import ssort_pkg::*;

  localparam int unsigned ReportLimit = 10;

  logic signed [DataW-1:0] held_values [StoreDepth];
  int unsigned             held_count;
  out_item_t               pending_sorted [$];

  always @(posedge clk) begin : track
    int unsigned             i;
    int unsigned             j;
    int unsigned             smallest;
    logic signed [DataW-1:0] swap_tmp;
    out_item_t               want;

    if (!rst_n) begin
      held_count = 0;
      pending_sorted.delete();
      mismatches = 0;
    end else begin
      if (pop && !empty) begin
        if (pending_sorted.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("unexpected result transaction: value %0d last %0b",
                     out_data.sorted_value, out_data.last_out);
          end
        end else begin
          want = pending_sorted.pop_front();
          if (out_data.sorted_value !== want.sorted_value ||
              out_data.last_out !== want.last_out) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("result mismatch: expected value %0d last %0b, got value %0d last %0b",
                       want.sorted_value, want.last_out,
                       out_data.sorted_value, out_data.last_out);
            end
          end
        end
      end

      if (push && !full) begin
        // values past capacity are dropped, but last still closes the set
        if (held_count < StoreDepth) begin
          held_values[held_count] = in_data.value;
          held_count++;
        end
        if (in_data.last) begin
          // selection sort, strict compare keeps the earlier of equal values
          for (i = 0; i + 1 < held_count; i++) begin
            smallest = i;
            for (j = i + 1; j < held_count; j++) begin
              if (held_values[smallest] > held_values[j]) smallest = j;
            end
            swap_tmp = held_values[smallest];
            held_values[smallest] = held_values[i];
            held_values[i] = swap_tmp;
          end
          for (i = 0; i < held_count; i++) begin
            want.sorted_value = held_values[i];
            want.last_out = (i + 1 == held_count);
            pending_sorted.push_back(want);
          end
          held_count = 0;
        end
      end
    end
    outstanding = pending_sorted.size();
  end

endmodule

`default_nettype wire

/* tb/sv/selection_sort_engine_test.sv */
// testbench top for the selection sort engine: stimulus, flow control and verdict
`default_nettype none

module selection_sort_engine_test;

  import ssort_pkg::*;

  localparam int unsigned StoreDepth  = 64;
  localparam int unsigned RandomItems = 480;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned IdlePct     = 21;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  in_item_t    in_data = '0;
  out_item_t   out_data;
  logic        full;
  logic        empty;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned tx_idle_pct = IdlePct;
  int unsigned rx_idle_pct = IdlePct;
  bit          rx_hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  selection_sort_engine #(
    .MAX_ELEMS(StoreDepth)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  sort_order_checker #(
    .StoreDepth(StoreDepth)
  ) order_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // offer one element, then hold it until the transaction completes
  task automatic send_value(input logic signed [DataW-1:0] elem, input logic closes);
    in_item_t item;
    item.value = elem;
    item.last = closes;
    @(negedge clk);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (full);
  endtask

  task automatic send_set(input int unsigned size);
    int unsigned             k;
    int unsigned             flavor;
    logic signed [DataW-1:0] v;
    flavor = $urandom_range(2, 0);
    for (k = 0; k < size; k++) begin
      if ($urandom_range(9, 0) == 0) begin
        v = $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
      end else if (flavor == 0) begin
        v = $urandom();
      end else if (flavor == 1) begin
        // narrow range gives plenty of equal values
        v = $signed($urandom_range(8, 0)) - 4;
      end else begin
        v = $urandom() & 32'h800000ff;
      end
      send_value(v, k + 1 == size);
    end
  endtask

  // sender goes quiet until every predicted result has come out
  task automatic wait_results_drained();
    @(negedge clk);
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic signed [DataW-1:0] corner_vals [10];
    int unsigned             k;
    int unsigned             sent;
    int unsigned             set_no;
    int unsigned             size;
    int unsigned             pick;

    corner_vals = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1,
                    32'sh80000000, 5, 5, -1, 32'sh7fffffff};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single element set
    send_value(32'sh7fffffff, 1'b1);
    // extremes and duplicates mixed
    for (k = 0; k < 10; k++) send_value(corner_vals[k], k == 9);
    // all equal
    for (k = 0; k < 4; k++) send_value(3, k == 3);
    // already ascending
    for (k = 0; k < 5; k++) send_value($signed(k) - 2, k == 4);

    sent = 0;
    set_no = 0;
    while (sent < RandomItems) begin
      if (set_no == 3) begin
        size = StoreDepth;
      end else if (set_no == 6) begin
        size = StoreDepth + 3;
      end else begin
        pick = $urandom_range(99, 0);
        if (pick < 85) size = $urandom_range(12, 1);
        else if (pick < 95) size = $urandom_range(40, 13);
        else size = $urandom_range(StoreDepth + 4, StoreDepth - 4);
      end

      if (set_no == 10) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (set_no == 25) begin
        tx_idle_pct = IdlePct;
        rx_idle_pct = IdlePct;
      end

      send_set(size);

      // receiver backs off while the next set keeps coming
      if (set_no == 8) rx_hold_req = 1'b1;
      if (set_no == 15 || set_no == 30) wait_results_drained();

      sent += size;
      set_no++;
    end

    @(negedge clk);
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned held;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        pop <= 1'b0;
        for (held = 1; held < HoldCycles; held++) @(negedge clk);
      end else begin
        pop <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

`default_nettype wire
